FILE: rtl/psll_pkg.sv
// Package for the Poisson log-likelihood block: sizes, op codes, state enums,
// and the elaboration-time exp power table and ln(g!) ROM.
// No dependencies.
`timescale 1ns / 1ps

package psll_pkg;

  localparam int TEAM_COUNT = 64;
  localparam int TEAM_W     = $clog2(TEAM_COUNT);
  localparam int MAX_GOALS  = 31;
  localparam int GOAL_W     = 5;
  localparam int STR_W      = 16;
  localparam int LR_W       = 18;   // log rate, signed Q.12
  localparam int OUT_W      = 48;
  localparam int TERM_W     = 50;   // unclamped match term
  localparam int EXPO_W     = 10;   // exponent of the wide float in the exp unit
  localparam int MANT_W     = 128;
  localparam int POW_N      = 17;   // one power per magnitude bit
  localparam int LF_W       = 24;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MATCH = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_LR, S_EXP1, S_EXP2, S_SUM, S_TOT
  } state_e;

  typedef enum logic [2:0] {
    X_IDLE, X_SCAN, X_MUL, X_NORM, X_ROUND
  } xstate_e;

  // restoring division of a wide word by a small divisor
  function automatic logic [MANT_W-1:0] div_small(logic [MANT_W-1:0] a, logic [4:0] k);
    logic [5:0]        rem;
    logic [MANT_W-1:0] q;
    rem = '0;
    q   = '0;
    for (int i = MANT_W - 1; i >= 0; i--) begin
      rem = {rem[4:0], a[i]};
      if (rem >= {1'b0, k}) begin
        rem  = rem - {1'b0, k};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem  = rem - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // mantissa of exp(+-2^-12), Taylor series on 128 fraction bits
  function automatic logic [MANT_W-1:0] exp_tiny(logic neg);
    logic [MANT_W-1:0] s;
    logic [MANT_W-1:0] t;
    s = '0;
    t = {{(MANT_W-1){1'b0}}, 1'b1} << 116;
    for (int k = 1; k <= 16; k++) begin
      if (k > 1) t = div_small(t >> 12, 5'(k));
      if (neg && (k % 2 == 0)) s = s - t;
      else s = s + t;
    end
    if (!neg) return (s >> 1) | ({{(MANT_W-1){1'b0}}, 1'b1} << (MANT_W - 1));
    return (~s) + {{(MANT_W-1){1'b0}}, 1'b1};
  endfunction

  // entry = {exponent, mantissa} of exp(+-2^i / 4096)
  function automatic logic [POW_N-1:0][EXPO_W+MANT_W-1:0] pow_table(logic neg);
    logic [POW_N-1:0][EXPO_W+MANT_W-1:0] tab;
    logic [MANT_W-1:0]   m;
    logic [2*MANT_W-1:0] p;
    int                  e;
    m = exp_tiny(neg);
    e = neg ? -128 : -127;
    for (int i = 0; i < POW_N; i++) begin
      if (i > 0) begin
        p = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
        if (p[2*MANT_W-1]) begin
          m = p[2*MANT_W-1 -: MANT_W];
          e = e + e + 128;
        end else begin
          m = p[2*MANT_W-2 -: MANT_W];
          e = e + e + 127;
        end
      end
      tab[i] = {EXPO_W'(e), m};
    end
    return tab;
  endfunction

  // 2*atanh(1/d) with 52 fraction bits
  function automatic logic [63:0] two_atanh(logic [63:0] d);
    logic [63:0] d2;
    logic [63:0] pw;
    logic [63:0] sum;
    d2  = d * d;
    pw  = udiv64(64'd1 << 52, d);
    sum = '0;
    for (int it = 0; it < 40; it++) begin
      if (pw != 64'd0) begin
        sum = sum + udiv64(pw, 64'(2 * it + 1));
        pw  = udiv64(pw, d2);
      end
    end
    return sum << 1;
  endfunction

  // round(ln(g!) * 4096)
  function automatic logic [MAX_GOALS:0][LF_W-1:0] lnfact_table();
    logic [MAX_GOALS:0][LF_W-1:0] tab;
    logic [63:0] lnk;
    logic [63:0] lf;
    lnk    = '0;
    lf     = '0;
    tab[0] = '0;
    for (int i = 1; i <= MAX_GOALS; i++) begin
      if (i >= 2) lnk = lnk + two_atanh(64'(2 * i - 1));
      lf     = lf + lnk;
      tab[i] = LF_W'((lf + (64'd1 << 39)) >> 40);
    end
    return tab;
  endfunction

  localparam logic [POW_N-1:0][EXPO_W+MANT_W-1:0] UP_POW = pow_table(1'b0);
  localparam logic [POW_N-1:0][EXPO_W+MANT_W-1:0] DN_POW = pow_table(1'b1);
  localparam logic [MAX_GOALS:0][LF_W-1:0]        LNFACT = lnfact_table();

endpackage

FILE: rtl/psll_exp_unit.sv
// Correctly rounded exp(arg/4096)*4096: product of per-bit powers on a 128-bit
// float, one 32x32 partial product per cycle. Depends on psll_pkg.
`timescale 1ns / 1ps

module psll_exp_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [psll_pkg::LR_W-1:0] arg_i,
  output logic                        idle_o,
  output logic                        done_o,
  output logic [psll_pkg::OUT_W-1:0]  result_o
);

  psll_pkg::xstate_e state_q, state_d;

  logic [psll_pkg::LR_W-2:0]           mag_q, mag_d;
  logic                                neg_q, neg_d;
  logic [4:0]                          bit_q, bit_d;
  logic [3:0]                          pp_q, pp_d;
  logic [psll_pkg::MANT_W-1:0]         acc_m_q, acc_m_d;
  logic signed [psll_pkg::EXPO_W-1:0]  acc_e_q, acc_e_d;
  logic [2*psll_pkg::MANT_W-1:0]       prod_q, prod_d;
  logic [psll_pkg::OUT_W-1:0]          res_q, res_d;
  logic                                done_q, done_d;

  logic [psll_pkg::EXPO_W+psll_pkg::MANT_W-1:0] pow_w;
  logic [psll_pkg::MANT_W-1:0]         c_m;
  logic signed [psll_pkg::EXPO_W-1:0]  c_e;
  logic [psll_pkg::LR_W-1:0]           arg_abs;
  logic [31:0]                         op_a, op_b;
  logic [63:0]                         partial;
  logic [2*psll_pkg::MANT_W-1:0]       partial_sh;
  logic [2:0]                          word_sum;
  logic signed [psll_pkg::EXPO_W:0]    sh_raw;
  logic [7:0]                          sh_amt;
  logic [psll_pkg::MANT_W-1:0]         shifted;
  logic                                round_bit;

  // power constant for the current magnitude bit
  assign pow_w = neg_q ? psll_pkg::DN_POW[bit_q] : psll_pkg::UP_POW[bit_q];
  assign c_m   = pow_w[psll_pkg::MANT_W-1:0];
  assign c_e   = pow_w[psll_pkg::EXPO_W+psll_pkg::MANT_W-1:psll_pkg::MANT_W];

  assign arg_abs = arg_i[psll_pkg::LR_W-1] ? psll_pkg::LR_W'(-arg_i) : arg_i;

  // shared 32x32 multiplier and shifted accumulate
  assign op_a       = acc_m_q[{pp_q[3:2], 5'b0} +: 32];
  assign op_b       = c_m[{pp_q[1:0], 5'b0} +: 32];
  assign partial    = op_a * op_b;
  assign word_sum   = {1'b0, pp_q[3:2]} + {1'b0, pp_q[1:0]};
  assign partial_sh = {{(2*psll_pkg::MANT_W-64){1'b0}}, partial} << {word_sum, 5'b0};

  // final rounding shift
  assign sh_raw    = -({acc_e_q[psll_pkg::EXPO_W-1], acc_e_q} + 11'sd12);
  assign sh_amt    = (sh_raw < 11'sd65) ? 8'd65 : sh_raw[7:0];
  assign shifted   = acc_m_q >> sh_amt;
  assign round_bit = acc_m_q[7'(sh_amt - 8'd1)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psll_pkg::X_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    bit_q   <= bit_d;
    pp_q    <= pp_d;
    acc_m_q <= acc_m_d;
    acc_e_q <= acc_e_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    bit_d   = bit_q;
    pp_d    = pp_q;
    acc_m_d = acc_m_q;
    acc_e_d = acc_e_q;
    prod_d  = prod_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      psll_pkg::X_IDLE: begin
        if (start_i) begin
          mag_d   = arg_abs[psll_pkg::LR_W-2:0];
          neg_d   = arg_i[psll_pkg::LR_W-1];
          bit_d   = '0;
          acc_m_d = {1'b1, {(psll_pkg::MANT_W-1){1'b0}}};
          acc_e_d = -10'sd127;
          state_d = psll_pkg::X_SCAN;
        end
      end
      psll_pkg::X_SCAN: begin
        if (bit_q == 5'(psll_pkg::POW_N)) begin
          state_d = psll_pkg::X_ROUND;
        end else if (mag_q[bit_q]) begin
          prod_d  = '0;
          pp_d    = '0;
          state_d = psll_pkg::X_MUL;
        end else begin
          bit_d = bit_q + 5'd1;
        end
      end
      psll_pkg::X_MUL: begin
        prod_d = prod_q + partial_sh;
        pp_d   = pp_q + 4'd1;
        if (pp_q == 4'd15) state_d = psll_pkg::X_NORM;
      end
      psll_pkg::X_NORM: begin
        if (prod_q[2*psll_pkg::MANT_W-1]) begin
          acc_m_d = prod_q[2*psll_pkg::MANT_W-1 -: psll_pkg::MANT_W];
          acc_e_d = acc_e_q + c_e + 10'sd128;
        end else begin
          acc_m_d = prod_q[2*psll_pkg::MANT_W-2 -: psll_pkg::MANT_W];
          acc_e_d = acc_e_q + c_e + 10'sd127;
        end
        bit_d   = bit_q + 5'd1;
        state_d = psll_pkg::X_SCAN;
      end
      psll_pkg::X_ROUND: begin
        if (sh_raw > 11'sd128) res_d = '0;
        else res_d = shifted[psll_pkg::OUT_W-1:0] + {{(psll_pkg::OUT_W-1){1'b0}}, round_bit};
        done_d  = 1'b1;
        state_d = psll_pkg::X_IDLE;
      end
      default: state_d = psll_pkg::X_IDLE;
    endcase
  end

  assign idle_o   = (state_q == psll_pkg::X_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/poisson_score_log_likelihood.sv
// Top level of the Poisson goal-model log-likelihood accumulator: stream ports,
// strength table, match sequencer. Depends on psll_pkg and psll_exp_unit.
`timescale 1ns / 1ps

// Load and clear items leave the input ready for the next item. A match item
// holds the input from its transfer until it is done: both exponentials run
// one after the other on the single exp unit, which scans every magnitude bit
// and spends, per set bit, sixteen 32x32 partial products and a normalize,
// then rounds and hands over. The input is not ready while a match is in
// work; a finished result waits in the output register and the next item can
// be accepted meanwhile. The strength table is undefined until loaded.
module poisson_score_log_likelihood (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,       // rate_scale
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // first_team[5:0], second_team[11:6], strength_value[27:12],
  // first_goals[32:28], second_goals[37:33], zero[39:38]
  input  logic [psll_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,    // operation[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // match_term[47:0], running_total[95:48]
  output logic [psll_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o     // overflow[0]
);

  localparam logic signed [psll_pkg::TERM_W-1:0] SAT_HI_T =
    psll_pkg::TERM_W'({1'b0, {(psll_pkg::OUT_W-1){1'b1}}});
  localparam logic signed [psll_pkg::TERM_W-1:0] SAT_LO_T =
    -psll_pkg::TERM_W'({1'b1, {(psll_pkg::OUT_W-1){1'b0}}});

  psll_pkg::state_e state_q, state_d;

  logic signed [psll_pkg::STR_W-1:0]  rate_q;
  logic signed [psll_pkg::STR_W-1:0]  mem [psll_pkg::TEAM_COUNT];
  logic signed [psll_pkg::STR_W-1:0]  rdata_q;
  logic [psll_pkg::TEAM_W-1:0]        rd_addr;
  logic                               in_xfer;
  psll_pkg::op_e                      op;

  logic [psll_pkg::TEAM_W-1:0]        team_b_q;
  logic [psll_pkg::GOAL_W-1:0]        g1_q, g2_q;
  logic signed [psll_pkg::STR_W-1:0]  s1_q;
  logic signed [psll_pkg::LR_W-1:0]   l1_q, l2_q;
  logic signed [psll_pkg::TERM_W-1:0] part_q, term_q;
  logic [psll_pkg::OUT_W-1:0]         e1_q, e2_q;
  logic                               tflag_q;
  logic signed [psll_pkg::OUT_W-1:0]  total_q;
  logic [psll_pkg::OUT_W-1:0]         out_term_q, out_total_q;
  logic                               out_flag_q, out_valid_q;

  logic                               exp_start, exp_idle, exp_done;
  logic signed [psll_pkg::LR_W-1:0]   exp_arg;
  logic [psll_pkg::OUT_W-1:0]         exp_res;

  logic [psll_pkg::GOAL_W-1:0]        g1_c, g2_c;
  logic signed [psll_pkg::LR_W+psll_pkg::GOAL_W:0] prod1, prod2;
  logic signed [psll_pkg::LR_W-1:0]   s1_x, s2_x, rate_x;
  logic signed [psll_pkg::TERM_W-1:0] term_raw;
  logic signed [psll_pkg::OUT_W:0]    total_raw;
  logic                               out_free;

  assign op      = psll_pkg::op_e'(s_axis_tuser_i);
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == psll_pkg::S_IDLE);
  assign out_free = !out_valid_q || m_axis_tready_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rate_q <= '0;
    else if (cfg_we_i) rate_q <= cfg_wdata_i;
  end

  // strength table, one write and one registered read port
  assign rd_addr = (state_q == psll_pkg::S_IDLE) ? s_axis_tdata_i[5:0] : team_b_q;
  always_ff @(posedge clk_i) begin
    if (in_xfer && op == psll_pkg::OP_LOAD) mem[s_axis_tdata_i[5:0]] <= s_axis_tdata_i[27:12];
    rdata_q <= mem[rd_addr];
  end

  psll_exp_unit u_exp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (exp_start),
    .arg_i    (exp_arg),
    .idle_o   (exp_idle),
    .done_o   (exp_done),
    .result_o (exp_res)
  );

  // side polynomial parts and sums
  assign g1_c   = (32'(g1_q) > psll_pkg::MAX_GOALS) ? psll_pkg::GOAL_W'(psll_pkg::MAX_GOALS) : g1_q;
  assign g2_c   = (32'(g2_q) > psll_pkg::MAX_GOALS) ? psll_pkg::GOAL_W'(psll_pkg::MAX_GOALS) : g2_q;
  assign prod1  = l1_q * $signed({1'b0, g1_c});
  assign prod2  = l2_q * $signed({1'b0, g2_c});
  assign s1_x   = psll_pkg::LR_W'(s1_q);
  assign s2_x   = psll_pkg::LR_W'(rdata_q);
  assign rate_x = psll_pkg::LR_W'(rate_q);
  assign term_raw  = part_q - $signed({2'b0, e1_q}) - $signed({2'b0, e2_q});
  // both operands sign-extended by one bit
  assign total_raw = {total_q[psll_pkg::OUT_W-1], total_q}
                   + {term_q[psll_pkg::OUT_W-1], term_q[psll_pkg::OUT_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psll_pkg::S_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer && op == psll_pkg::OP_CLEAR) total_q <= '0;
      if (state_q == psll_pkg::S_TOT && out_free) begin
        if (total_raw > $signed({2'b0, {(psll_pkg::OUT_W-1){1'b1}}}))
          total_q <= {1'b0, {(psll_pkg::OUT_W-1){1'b1}}};
        else if (total_raw < -$signed({2'b01, {(psll_pkg::OUT_W-1){1'b0}}}))
          total_q <= {1'b1, {(psll_pkg::OUT_W-1){1'b0}}};
        else total_q <= total_raw[psll_pkg::OUT_W-1:0];
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      team_b_q <= s_axis_tdata_i[11:6];
      g1_q     <= s_axis_tdata_i[32:28];
      g2_q     <= s_axis_tdata_i[37:33];
    end
    if (state_q == psll_pkg::S_RD1) s1_q <= rdata_q;
    if (state_q == psll_pkg::S_RD2) begin
      l1_q <= s1_x - s2_x + rate_x;
      l2_q <= s2_x - s1_x + rate_x;
    end
    if (state_q == psll_pkg::S_LR) begin
      part_q <= psll_pkg::TERM_W'(prod1) + psll_pkg::TERM_W'(prod2)
              - $signed({{(psll_pkg::TERM_W-psll_pkg::LF_W){1'b0}}, psll_pkg::LNFACT[g1_c]})
              - $signed({{(psll_pkg::TERM_W-psll_pkg::LF_W){1'b0}}, psll_pkg::LNFACT[g2_c]});
    end
    if (state_q == psll_pkg::S_EXP1 && exp_done) e1_q <= exp_res;
    if (state_q == psll_pkg::S_EXP2 && exp_done) e2_q <= exp_res;
    if (state_q == psll_pkg::S_SUM) begin
      if (term_raw > SAT_HI_T) begin
        term_q  <= SAT_HI_T;
        tflag_q <= 1'b1;
      end else if (term_raw < SAT_LO_T) begin
        term_q  <= SAT_LO_T;
        tflag_q <= 1'b1;
      end else begin
        term_q  <= term_raw;
        tflag_q <= 1'b0;
      end
    end
    if (state_q == psll_pkg::S_TOT && out_free) begin
      out_term_q  <= term_q[psll_pkg::OUT_W-1:0];
      out_flag_q  <= tflag_q
                  || (total_raw > $signed({2'b0, {(psll_pkg::OUT_W-1){1'b1}}}))
                  || (total_raw < -$signed({2'b01, {(psll_pkg::OUT_W-1){1'b0}}}));
      if (total_raw > $signed({2'b0, {(psll_pkg::OUT_W-1){1'b1}}}))
        out_total_q <= {1'b0, {(psll_pkg::OUT_W-1){1'b1}}};
      else if (total_raw < -$signed({2'b01, {(psll_pkg::OUT_W-1){1'b0}}}))
        out_total_q <= {1'b1, {(psll_pkg::OUT_W-1){1'b0}}};
      else out_total_q <= total_raw[psll_pkg::OUT_W-1:0];
    end
  end

  // match sequencer
  always_comb begin
    state_d   = state_q;
    exp_start = 1'b0;
    exp_arg   = l1_q;
    unique case (state_q)
      psll_pkg::S_IDLE: if (in_xfer && op == psll_pkg::OP_MATCH) state_d = psll_pkg::S_RD1;
      psll_pkg::S_RD1:  state_d = psll_pkg::S_RD2;
      psll_pkg::S_RD2:  state_d = psll_pkg::S_LR;
      psll_pkg::S_LR: begin
        exp_start = 1'b1;
        state_d   = psll_pkg::S_EXP1;
      end
      psll_pkg::S_EXP1: begin
        if (exp_done) begin
          exp_start = 1'b1;
          exp_arg   = l2_q;
          state_d   = psll_pkg::S_EXP2;
        end
      end
      psll_pkg::S_EXP2: if (exp_done) state_d = psll_pkg::S_SUM;
      psll_pkg::S_SUM:  state_d = psll_pkg::S_TOT;
      psll_pkg::S_TOT:  if (out_free) state_d = psll_pkg::S_IDLE;
      default: state_d = psll_pkg::S_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_total_q, out_term_q};
  assign m_axis_tuser_o  = out_flag_q;

  // a new result appears only when the sequencer finishes a match
  a_out_from_tot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == psll_pkg::S_TOT)
    else $error("result without a finished match");

  // the exp unit is never started while it is busy
  a_exp_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_start |-> exp_idle)
    else $error("exp unit started while busy");

  // a clear transfer empties the running total
  a_clear_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op == psll_pkg::OP_CLEAR) |=> total_q == '0)
    else $error("running total not cleared");

  // exp results arrive only while the sequencer waits for one
  a_exp_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_done |-> (state_q == psll_pkg::S_EXP1 || state_q == psll_pkg::S_EXP2))
    else $error("unexpected exp result");

endmodule

FILE: tb/sv/tb_poisson_score_log_likelihood.sv
// Self-checking testbench for poisson_score_log_likelihood: stream stimulus,
// a wide fixed-point predictor of the match score, and a result checker.
// Depends on psll_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_poisson_score_log_likelihood;

  localparam longint SAT_HI      = 64'sd140737488355327;
  localparam longint SAT_LO      = -64'sd140737488355328;
  localparam int     CYCLE_LIMIT = 4000000;
  localparam int     DRAIN_WAIT  = 700;
  localparam int     FRAC        = 200;   // fraction bits of the exp arithmetic
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [47:0] term;
    logic [47:0] total;
    logic        ovf;
  } score_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [15:0]                     cfg_wdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [psll_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [1:0]                      s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [psll_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [0:0]                      m_tuser;

  // predictor state
  logic signed [15:0] team_str [psll_pkg::TEAM_COUNT];
  bit                 team_loaded [psll_pkg::TEAM_COUNT];
  longint             pred_total;
  logic signed [15:0] pred_scale;
  longint             lnfact_q12 [psll_pkg::MAX_GOALS+1];
  logic [255:0]       exp_up [17];
  logic [255:0]       exp_dn [17];
  score_t             score_q [$];

  int  mismatches;
  int  cycles;
  bit  idle_en;
  bit  hold_arm;
  int  hold_cnt;
  int  stall_cnt;

  poisson_score_log_likelihood uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // fixed-point multiply with FRAC fraction bits
  function automatic logic [255:0] fx_mul(logic [255:0] a, logic [255:0] b);
    logic [511:0] p;
    p = {256'd0, a} * {256'd0, b};
    return p[FRAC +: 256];
  endfunction

  // exp(+-1/4096) by Taylor series, then repeated squaring
  task automatic build_exp_tables();
    logic [255:0] s;
    logic [255:0] t;
    for (int neg = 0; neg < 2; neg++) begin
      s = 256'd1 << FRAC;
      t = 256'd1 << FRAC;
      for (int k = 1; k <= 20; k++) begin
        t = t / (256'd4096 * k);
        if (neg == 1 && (k % 2 == 1)) s = s - t;
        else s = s + t;
      end
      for (int i = 0; i < 17; i++) begin
        if (i > 0) s = fx_mul(s, s);
        if (neg == 1) exp_dn[i] = s;
        else exp_up[i] = s;
      end
    end
  endtask

  task automatic build_lnfact();
    real acc;
    acc = 0.0;
    for (int g = 0; g <= psll_pkg::MAX_GOALS; g++) begin
      if (g >= 2) acc = acc + $ln(g);
      lnfact_q12[g] = longint'($floor(acc * 4096.0 + 0.5));
    end
  endtask

  // round-half-up of exp(n/4096)*4096
  function automatic longint exp_q12(int n);
    logic [255:0] acc;
    logic [255:0] r;
    int           mag;
    acc = 256'd1 << FRAC;
    mag = (n < 0) ? -n : n;
    for (int i = 0; i < 17; i++)
      if (mag[i]) acc = fx_mul(acc, (n < 0) ? exp_dn[i] : exp_up[i]);
    r = (acc + (256'd1 << (FRAC - 13))) >> (FRAC - 12);
    return longint'(r[63:0]);
  endfunction

  function automatic longint clamp48(longint v, inout bit sat);
    if (v > SAT_HI) begin
      sat = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      sat = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  function automatic longint side_score(int lrate, int goals);
    return longint'(lrate) * goals - lnfact_q12[goals] - exp_q12(lrate);
  endfunction

  // predictor: consumes one accepted item, queues a score for matches
  task automatic predict_item(logic [1:0] op, int a, int b, logic [15:0] str,
                              int g1, int g2);
    int     l1;
    int     l2;
    longint term;
    bit     sat;
    score_t sc;
    case (op)
      psll_pkg::OP_LOAD: begin
        team_str[a]    = str;
        team_loaded[a] = 1'b1;
      end
      psll_pkg::OP_CLEAR: pred_total = 0;
      psll_pkg::OP_MATCH: begin
        sat        = 1'b0;
        l1         = int'(team_str[a]) - int'(team_str[b]) + int'(pred_scale);
        l2         = int'(team_str[b]) - int'(team_str[a]) + int'(pred_scale);
        term       = clamp48(side_score(l1, g1) + side_score(l2, g2), sat);
        pred_total = clamp48(pred_total + term, sat);
        sc.term    = term[47:0];
        sc.total   = pred_total[47:0];
        sc.ovf     = sat;
        score_q.push_back(sc);
      end
      default: ;
    endcase
  endtask

  // send one item, with an optional random gap before it
  task automatic send_item(logic [1:0] op, int a, int b, logic [15:0] str,
                           int g1, int g2);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, 5'(g2), 5'(g1), str, 6'(b), 6'(a)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(op, a, b, str, g1, g2);
  endtask

  // wait for all scores, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pred_scale = v;
    @(posedge clk);
  endtask

  function automatic int pick_loaded();
    int t;
    t = $urandom_range(0, psll_pkg::TEAM_COUNT - 1);
    while (!team_loaded[t]) t = (t + 1) % psll_pkg::TEAM_COUNT;
    return t;
  endfunction

  function automatic int rand_goals();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, psll_pkg::MAX_GOALS);
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [15:0] rand_strength();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  // mix of loads, matches, clears and unused codes
  task automatic send_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)
        send_item(psll_pkg::OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                  rand_strength(), $urandom_range(0, 31), $urandom_range(0, 31));
      else if (r < 90)
        send_item(psll_pkg::OP_MATCH, pick_loaded(), pick_loaded(), 16'($urandom),
                  rand_goals(), rand_goals());
      else if (r < 95)
        send_item(psll_pkg::OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                  16'($urandom), $urandom_range(0, 31), $urandom_range(0, 31));
      else
        send_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                  16'($urandom), $urandom_range(0, 31), $urandom_range(0, 31));
    end
  endtask

  // extremes of strength, goals and rate scale, and every op code
  task automatic test_directed();
    send_item(psll_pkg::OP_LOAD, 0, 0, 16'h7FFF, 0, 0);
    send_item(psll_pkg::OP_LOAD, 63, 0, 16'h8000, 0, 0);
    send_item(psll_pkg::OP_LOAD, 1, 0, 16'h0000, 0, 0);
    send_item(psll_pkg::OP_LOAD, 2, 0, 16'h1000, 0, 0);
    send_item(psll_pkg::OP_MATCH, 1, 2, 16'h0000, 0, 0);
    send_item(psll_pkg::OP_MATCH, 2, 1, 16'h0000, 31, 31);
    send_item(psll_pkg::OP_MATCH, 1, 1, 16'h0000, 3, 0);
    send_item(OP_UNUSED, 63, 63, 16'hFFFF, 31, 31);
    send_item(psll_pkg::OP_MATCH, 0, 63, 16'h0000, 31, 0);
    send_item(psll_pkg::OP_MATCH, 63, 0, 16'h0000, 0, 31);
    send_item(psll_pkg::OP_MATCH, 0, 63, 16'h0000, 0, 0);
    send_item(psll_pkg::OP_MATCH, 0, 63, 16'h0000, 0, 0);
    send_item(psll_pkg::OP_CLEAR, 0, 0, 16'h0000, 0, 0);
    send_item(psll_pkg::OP_MATCH, 0, 0, 16'h0000, 31, 31);
    send_item(psll_pkg::OP_MATCH, 63, 63, 16'h0000, 1, 2);
    wait_idle();
    write_scale(16'h7FFF);
    send_item(psll_pkg::OP_MATCH, 0, 63, 16'h0000, 31, 31);
    send_item(psll_pkg::OP_MATCH, 1, 2, 16'h0000, 7, 0);
    wait_idle();
    write_scale(16'h8000);
    send_item(psll_pkg::OP_MATCH, 0, 63, 16'h0000, 31, 31);
    send_item(psll_pkg::OP_MATCH, 2, 1, 16'h0000, 0, 5);
    wait_idle();
  endtask

  task automatic test_scale_sweep();
    logic [15:0] scales [4];
    scales[0] = 16'h8000;
    scales[1] = 16'h7FFF;
    scales[2] = 16'($urandom);
    scales[3] = 16'h0000;
    for (int i = 0; i < 4; i++) begin
      write_scale(scales[i]);
      send_random(160);
      wait_idle();
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_arm = 1'b1;
    send_random(40);
    wait_idle();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    send_random(160);
    s_tvalid <= 1'b0;
  endtask

  // receiver: check each transfer, then schedule stalls
  always @(posedge clk or negedge rst_n) begin
    score_t sc;
    if (!rst_n) begin
      m_tready  <= 1'b0;
      hold_cnt  <= 0;
      stall_cnt <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (score_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected score transfer %h", m_tdata);
        end else begin
          sc = score_q.pop_front();
          if (m_tdata[47:0] !== sc.term || m_tdata[95:48] !== sc.total ||
              m_tuser[0] !== sc.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("score mismatch: exp term %h total %h ovf %b, got %h %h %b",
                       sc.term, sc.total, sc.ovf,
                       m_tdata[47:0], m_tdata[95:48], m_tuser[0]);
          end
        end
      end
      if (hold_arm) begin
        hold_arm = 1'b0;
        hold_cnt <= 3000;
        m_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        m_tready  <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_cnt <= $urandom_range(0, 8);
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    mismatches = 0;
    cycles     = 0;
    idle_en    = 1'b1;
    hold_arm   = 1'b0;
    pred_total = 0;
    pred_scale = '0;
    for (int i = 0; i < psll_pkg::TEAM_COUNT; i++) begin
      team_str[i]    = '0;
      team_loaded[i] = 1'b0;
    end
    build_exp_tables();
    build_lnfact();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_scale_sweep();
    test_backpressure();
    test_no_idle();

    wait_idle();
    if (mismatches == 0 && score_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
